FILE: sv/pfgr_pkg.sv
// Shared types and constants for the paged framebuffer glyph renderer.
package pfgr_pkg;

	localparam int FB_BYTES   = 1024;
	localparam int FONT_DEPTH = 512;
	localparam int PAGE_BITS  = 8;
	localparam int GLYPH_COLS = 5;

	localparam logic [7:0] UNUSED_COL  = 8'h80;
	localparam logic [6:0] FIRST_CODE  = 7'd32;
	localparam logic [6:0] LAST_CODE   = 7'd126;
	localparam logic [7:0] WIDTH_RESET = 8'd128;
	localparam logic [6:0] HEIGHT_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

FILE: sv/pfgr_if.sv
// Handshake channel interfaces for commands, results and configuration writes.
interface pfgr_cmd_if;
	logic              valid;
	logic              ready;
	pfgr_pkg::op_t     operation;
	logic signed [8:0] x_origin;
	logic signed [8:0] y_origin;
	logic [6:0]        char_code;
	logic              invert_pixels;
	logic              double_size;
	logic              measure_only;
	logic [8:0]        font_index;
	logic [7:0]        font_byte;
	logic [9:0]        fb_address;
	modport source (output valid, operation, x_origin, y_origin, char_code, invert_pixels,
		double_size, measure_only, font_index, font_byte, fb_address, input ready);
	modport sink (input valid, operation, x_origin, y_origin, char_code, invert_pixels,
		double_size, measure_only, font_index, font_byte, fb_address, output ready);
endinterface

interface pfgr_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] advance;
	logic [7:0] read_data;
	logic       status;
	modport source (output valid, advance, read_data, status, input ready);
	modport sink (input valid, advance, read_data, status, output ready);
endinterface

interface pfgr_cfg_if;
	logic                 valid;
	logic                 ready;
	pfgr_pkg::reg_idx_t   index;
	logic [7:0]           data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/paged_framebuffer_glyph_renderer.sv
// Top level of the paged framebuffer glyph renderer.
// The framebuffer is a 1024-byte memory and the font a 512-byte memory, both with
// registered reads. After reset, and for every clear command, a pass writes zero to
// every framebuffer byte, one a cycle, during which no command is taken. A font load or
// an invalid code goes straight to the done state, and a framebuffer read passes first
// through its read state. A draw reads its five font bytes, then walks every column
// over three page slots, each slot in a check state, followed by a write state for each
// framebuffer byte that it changes by read, modify and write; a measure-only draw stops
// after the font reads. A finished result waits in an output register while the next
// command is taken.
module paged_framebuffer_glyph_renderer (
	input  logic        clk,
	input  logic        arst_n,
	pfgr_cmd_if.sink    cmd,
	pfgr_rsp_if.source  rsp,
	pfgr_cfg_if.sink    cfg
);
	import pfgr_pkg::*;

	typedef enum logic [7:0] {
		ST_CLR  = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_GLY  = 8'b0000_0100,
		ST_CHK  = 8'b0000_1000,
		ST_WR   = 8'b0001_0000,
		ST_FBD  = 8'b0010_0000,
		ST_DONE = 8'b0100_0000
	} state_t;

	state_t            state_q;
	logic [9:0]        clr_cnt_q;
	logic [7:0]        sw_q;
	logic [6:0]        sh_q;
	op_t               op_q;
	logic signed [8:0] x_q;
	logic signed [8:0] y_q;
	logic              inv_q, big_q, bad_q;
	logic              cmd_dry_q;
	logic [8:0]        base_q;
	logic [2:0]        gi_q;
	logic [7:0]        g_q [GLYPH_COLS];
	logic [3:0]        col_q;
	logic [1:0]        pg_q;
	logic [9:0]        wa_q;
	logic [7:0]        wm_q, wv_q, rd_q;
	logic              ov_q;
	logic [3:0]        adv_q;
	logic [7:0]        rdo_q;
	logic              st_q;

	logic [7:0] fb_mem [FB_BYTES];
	logic [7:0] gly_mem [FONT_DEPTH];
	logic [7:0] fb_rdata_q, gly_rdata_q;
	logic       fb_we;
	logic [9:0] fb_wa, fb_ra;
	logic [7:0] fb_wd;
	logic       gly_we;
	logic [8:0] gly_ra;

	logic        acc;
	logic [2:0]  w;
	logic signed [9:0] cx;
	logic        x_ok, skip_col, page_ok, idx_ok, last_col, out_free;
	logic [7:0]  e, pb, cb, rowmask, m;
	logic [15:0] pat, cov;
	logic [23:0] pat24, cov24;
	logic [6:0]  pgs;
	logic [11:0] idx;
	logic [6:0]  code_off;

	assign acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		w = 3'd0;
		for (int i = 0; i < GLYPH_COLS; i++) begin
			w = w + 3'((g_q[i] != UNUSED_COL) ? 1 : 0);
		end
	end

	always_comb begin
		cx = $signed({x_q[8], x_q}) + $signed({6'b0, col_q});
		x_ok = !cx[9] && ({1'b0, cx[8:0]} < {2'b0, sw_q});
		if (big_q) begin
			e = g_q[col_q[3:1]];
		end else if (col_q < {1'b0, w}) begin
			e = g_q[col_q[2:0]];
		end else begin
			e = 8'd0;
		end
		for (int r = 0; r < 16; r++) begin
			pat[r] = big_q ? e[r / 2] : ((r < 8) ? e[r % 8] : 1'b0);
		end
		cov = big_q ? 16'hFFFF : 16'h00FF;
		skip_col = big_q && (e == UNUSED_COL);
		pat24 = {8'd0, pat} << y_q[2:0];
		cov24 = {8'd0, cov} << y_q[2:0];
		case (pg_q)
			2'd0: begin
				pb = pat24[7:0];
				cb = cov24[7:0];
			end
			2'd1: begin
				pb = pat24[15:8];
				cb = cov24[15:8];
			end
			default: begin
				pb = pat24[23:16];
				cb = cov24[23:16];
			end
		endcase
		pgs = {y_q[8], y_q[8:3]} + {5'd0, pg_q};
		page_ok = !pgs[6] && (pgs[5:4] == 2'd0);
		for (int b = 0; b < 8; b++) begin
			rowmask[b] = ({pgs[3:0], 3'(b)} < sh_q);
		end
		idx = 12'(sw_q * pgs[3:0]) + {4'd0, cx[7:0]};
		idx_ok = (idx[11:10] == 2'd0);
		m = cb & rowmask & {8{page_ok && x_ok && !skip_col && idx_ok}};
		last_col = big_q ? (col_q == 4'd9) : (col_q == {1'b0, w});
	end

	always_comb begin
		fb_we = 1'b0;
		fb_wa = wa_q;
		fb_wd = (fb_rdata_q & ~wm_q) | (wv_q & wm_q);
		fb_ra = idx[9:0];
		case (state_q)
			ST_CLR: begin
				fb_we = 1'b1;
				fb_wa = clr_cnt_q;
				fb_wd = 8'd0;
			end
			ST_WR: fb_we = 1'b1;
			ST_IDLE: fb_ra = cmd.fb_address;
			default: fb_we = 1'b0;
		endcase
		gly_we = acc && (cmd.operation == OP_LOAD);
		gly_ra = base_q + {6'd0, gi_q};
		code_off = cmd.char_code - FIRST_CODE;
	end

	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[fb_wa] <= fb_wd;
		end
		fb_rdata_q <= fb_mem[fb_ra];
	end

	always_ff @(posedge clk) begin
		if (gly_we) begin
			gly_mem[cmd.font_index] <= cmd.font_byte;
		end
		gly_rdata_q <= gly_mem[gly_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			x_q <= cmd.x_origin;
			y_q <= cmd.y_origin;
			inv_q <= cmd.invert_pixels;
			big_q <= cmd.double_size;
			bad_q <= (cmd.char_code < FIRST_CODE) || (cmd.char_code > LAST_CODE);
			base_q <= 9'(code_off * 3'd5);
			rd_q <= 8'd0;
		end
		if (state_q == ST_GLY && gi_q != 3'd0) begin
			g_q[gi_q - 3'd1] <= gly_rdata_q;
		end
		if (state_q == ST_CHK) begin
			wa_q <= idx[9:0];
			wm_q <= m;
			wv_q <= pb ^ {8{inv_q}};
		end
		if (state_q == ST_FBD) begin
			rd_q <= fb_rdata_q;
		end
		if (state_q == ST_DONE && out_free) begin
			adv_q <= 4'd0;
			rdo_q <= (op_q == OP_READ) ? rd_q : 8'd0;
			st_q <= (op_q == OP_DRAW) && bad_q;
			if (op_q == OP_DRAW && !bad_q) begin
				adv_q <= big_q ? ({w, 1'b0} + 4'd2) : ({1'b0, w} + 4'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			op_q <= OP_LOAD;
			clr_cnt_q <= '0;
			sw_q <= WIDTH_RESET;
			sh_q <= HEIGHT_RESET;
			gi_q <= '0;
			col_q <= '0;
			pg_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SCREEN_WIDTH) begin
					sw_q <= cfg.data;
				end else begin
					sh_q <= cfg.data[6:0];
				end
			end
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 10'd1;
					if (clr_cnt_q == 10'(FB_BYTES - 1)) begin
						state_q <= (op_q == OP_CLEAR) ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						op_q <= cmd.operation;
						gi_q <= '0;
						col_q <= '0;
						pg_q <= '0;
						clr_cnt_q <= '0;
						case (cmd.operation)
							OP_LOAD: state_q <= ST_DONE;
							OP_READ: state_q <= ST_FBD;
							OP_CLEAR: state_q <= ST_CLR;
							default: begin
								if ((cmd.char_code < FIRST_CODE) ||
									(cmd.char_code > LAST_CODE)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_GLY;
								end
							end
						endcase
					end
				end
				ST_GLY: begin
					gi_q <= gi_q + 3'd1;
					if (gi_q == 3'(GLYPH_COLS)) begin
						state_q <= cmd_dry_q ? ST_DONE : ST_CHK;
					end
				end
				ST_CHK, ST_WR: begin
					if (state_q == ST_CHK && m != 8'd0) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_CHK;
						if (pg_q == 2'd2) begin
							pg_q <= '0;
							col_q <= col_q + 4'd1;
							if (last_col) begin
								state_q <= ST_DONE;
							end
						end else begin
							pg_q <= pg_q + 2'd1;
						end
					end
				end
				ST_FBD: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						ov_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			cmd_dry_q <= cmd.measure_only;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.advance = adv_q;
	assign rsp.read_data = rdo_q;
	assign rsp.status = st_q;

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		fb_we |-> (state_q == ST_WR || state_q == ST_CLR))
		else $error("Framebuffer written outside a write or clear cycle.");
	a_wr_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> $past(state_q) == ST_CHK)
		else $error("Byte write not preceded by its read.");
	a_bad_no_adv: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.advance == 4'd0)
		else $error("Invalid code reported with a non-zero advance.");
	a_adv_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.advance <= 4'd12)
		else $error("Advance above twelve columns.");

endmodule
